// ===== src/ffha_pkg.sv =====
// Package for the first-fit heap allocator: sizes, header layout, codes and states.
// Used by ffha_hdr_ram, first_fit_heap_allocator and the testbench; depends on nothing else.
package ffha_pkg;

   localparam int HEAP_BYTES   = 65536;
   localparam int ALIGN_BYTES  = 8;
   localparam int HEADER_BYTES = 16;

   localparam int POS_W     = $clog2(HEAP_BYTES + 1);
   localparam int SIZE_W    = POS_W;
   localparam int ALIGN_SH  = $clog2(ALIGN_BYTES);
   localparam int HDR_AW    = $clog2(HEAP_BYTES / ALIGN_BYTES);
   localparam int HDR_DEPTH = HEAP_BYTES / ALIGN_BYTES;
   localparam int LEN_W     = 24;
   localparam int NEED_W    = LEN_W + 1;
   localparam int PTR_W     = 16;
   localparam int CFG_W     = 17;
   localparam int CNT_W     = 32;

   localparam logic [POS_W-1:0]  HDR_P      = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0]  MIN_CAP    = POS_W'(HEADER_BYTES + ALIGN_BYTES);
   localparam logic [NEED_W-1:0] MIN_SPLIT  = NEED_W'(HEADER_BYTES + ALIGN_BYTES);
   localparam logic [NEED_W-1:0] ALIGN_MASK = NEED_W'(ALIGN_BYTES - 1);
   localparam logic [CFG_W-1:0]  HEAP_CAP   = CFG_W'(HEAP_BYTES);
   localparam logic [CFG_W-1:0]  CFG_ALIGN  = CFG_W'(ALIGN_BYTES - 1);

   typedef struct packed {
      logic              free;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   typedef struct packed {
      logic              en;
      logic [HDR_AW-1:0] addr;
      hdr_type           data;
   } ram_wr_type;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_FREE    = 2'd1,
      OP_REALLOC = 2'd2,
      OP_STATS   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_PTR       = 3'd0,
      ST_DONE      = 3'd1,
      ST_FAIL      = 3'd2,
      ST_IGNORED   = 3'd3,
      ST_MOVED     = 3'd4,
      ST_NOT_READY = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT,
      S_A_WALK,
      S_SPLIT,
      S_F_WALK,
      S_R_NEXT,
      S_FREE_WR,
      S_M_START,
      S_M_WALK,
      S_S_WALK
   } state_type;

endpackage

// ===== src/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator: command FSM, header walks, APB register.
// Depends on ffha_pkg and ffha_hdr_ram.
//
//  channel   ports                 handshake
//  request   req_*                 taken when start high and busy low
//  response  rsp_*                 rsp_valid strobe, one cycle, no backpressure
//  config    csr_*                 APB write of heap_bytes, pready always high
//
// Each request walks the block chain from offset 0, one header per cycle through the
// header RAM read port: allocate and statistics take one walk, free a walk to the target
// and then a full merge pass from offset 0, and a moving reallocate adds an allocate walk.
// Trivial requests are answered from the idle state without a walk.
// After reset or a heap_bytes write, state S_INIT writes the initial header if the heap is large enough (busy high).
module first_fit_heap_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [1:0]                       req_operation,
   input  logic                             req_pointer_given,
   input  logic [ffha_pkg::PTR_W-1:0]       req_pointer_offset,
   input  logic [ffha_pkg::LEN_W-1:0]       req_length,
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_status,
   output logic [ffha_pkg::PTR_W-1:0]       rsp_result_offset,
   output logic [ffha_pkg::PTR_W-1:0]       rsp_copy_source,
   output logic [ffha_pkg::SIZE_W-1:0]      rsp_copy_bytes,
   output logic [ffha_pkg::SIZE_W-1:0]      rsp_free_total,
   output logic [ffha_pkg::SIZE_W-1:0]      rsp_used_total,
   output logic [ffha_pkg::SIZE_W-1:0]      rsp_largest_free,
   output logic [ffha_pkg::CNT_W-1:0]       rsp_failures_seen,
   output logic [ffha_pkg::LEN_W-1:0]       rsp_last_failed_size,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [1:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int POS_W  = ffha_pkg::POS_W;
   localparam int SIZE_W = ffha_pkg::SIZE_W;
   localparam int NEED_W = ffha_pkg::NEED_W;

   ffha_pkg::state_type state_ff, state_in;

   logic [ffha_pkg::CFG_W-1:0] heap_bytes_ff;
   logic [ffha_pkg::CNT_W-1:0] fail_cnt_ff;
   logic [ffha_pkg::LEN_W-1:0] last_fail_ff;

   ffha_pkg::op_type           op_ff, op_in;
   logic [ffha_pkg::LEN_W-1:0] len_ff, len_in;
   logic [ffha_pkg::PTR_W-1:0] ptr_ff, ptr_in;
   logic [NEED_W-1:0]          need_ff, need_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [POS_W-1:0]           p_ff, p_in;
   logic [SIZE_W-1:0]          psize_ff, psize_in;
   logic [ffha_pkg::PTR_W-1:0] res_ff, res_in;
   logic                       moving_ff, moving_in;
   logic [POS_W-1:0]           sp_pos_ff, sp_pos_in;
   ffha_pkg::hdr_type          sp_data_ff, sp_data_in;
   logic                       run_ff, run_in;
   logic                       grew_ff, grew_in;
   logic [POS_W-1:0]           run_pos_ff, run_pos_in;
   logic [SIZE_W-1:0]          run_size_ff, run_size_in;
   logic [SIZE_W-1:0]          ftot_ff, ftot_in;
   logic [SIZE_W-1:0]          utot_ff, utot_in;
   logic [SIZE_W-1:0]          big_ff, big_in;

   logic                       rsp_valid_ff;
   ffha_pkg::status_type       rsp_status_ff;
   logic [ffha_pkg::PTR_W-1:0] rsp_res_ff, rsp_src_ff;
   logic [SIZE_W-1:0]          rsp_cnt_ff, rsp_ftot_ff, rsp_utot_ff, rsp_big_ff;
   logic [ffha_pkg::CNT_W-1:0] rsp_fails_ff;
   logic [ffha_pkg::LEN_W-1:0] rsp_lastf_ff;

   // finishing result
   logic                       fin;
   logic                       fin_fail;
   ffha_pkg::status_type       fin_status;
   logic [ffha_pkg::PTR_W-1:0] fin_res, fin_src;
   logic [SIZE_W-1:0]          fin_cnt, fin_ftot, fin_utot, fin_big;
   logic [ffha_pkg::LEN_W-1:0] fail_len;
   logic [ffha_pkg::CNT_W-1:0] fail_cnt_in;
   logic [ffha_pkg::LEN_W-1:0] last_fail_in;

   ffha_pkg::ram_wr_type       wr;
   ffha_pkg::hdr_type          hdr;

   logic [ffha_pkg::CFG_W-1:0] cap_lim;
   logic [POS_W-1:0]           cap;
   logic                       ready;
   logic                       csr_wr;
   logic                       accept;

   logic                       at_end;
   logic [POS_W-1:0]           pos_next;
   logic [POS_W-1:0]           blk_base;
   logic [SIZE_W-1:0]          blk_size;
   logic [SIZE_W-1:0]          comb_size;
   logic                       blk_split;
   logic [SIZE_W-1:0]          blk_rest;
   logic [POS_W-1:0]           blk_rest_pos;
   logic [POS_W-1:0]           ptr_pos;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == '0) ? {{(32 - ffha_pkg::CFG_W){1'b0}}, heap_bytes_ff}
                                         : '0;

   assign cap_lim = (heap_bytes_ff > ffha_pkg::HEAP_CAP) ? ffha_pkg::HEAP_CAP : heap_bytes_ff;
   assign cap     = POS_W'(cap_lim & ~ffha_pkg::CFG_ALIGN);
   assign ready   = cap >= ffha_pkg::MIN_CAP;

   assign busy   = state_ff != ffha_pkg::S_IDLE;
   assign accept = start && !busy;

   ffha_hdr_ram u_hdr_ram (
      .clock      (clock),
      .wr         (wr),
      .rd_addr    (pos_in[ffha_pkg::ALIGN_SH +: ffha_pkg::HDR_AW]),
      .rd_data_ff (hdr)
   );

   assign at_end    = !ready || pos_ff >= cap;
   assign pos_next  = pos_ff + ffha_pkg::HDR_P + hdr.size;
   assign comb_size = psize_ff + ffha_pkg::HDR_P + hdr.size;
   assign ptr_pos   = {1'b0, ptr_ff};

   // block being placed: the walked block, or the grown block when absorbing a neighbor
   always_comb begin
      if (state_ff == ffha_pkg::S_R_NEXT) begin
         blk_base = p_ff;
         blk_size = comb_size;
      end else begin
         blk_base = pos_ff;
         blk_size = hdr.size;
      end
   end

   assign blk_split    = NEED_W'(blk_size) >= need_ff + ffha_pkg::MIN_SPLIT;
   assign blk_rest     = blk_size - SIZE_W'(need_ff) - ffha_pkg::HDR_P;
   assign blk_rest_pos = blk_base + ffha_pkg::HDR_P + POS_W'(need_ff);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      len_in      = len_ff;
      ptr_in      = ptr_ff;
      need_in     = need_ff;
      pos_in      = pos_ff;
      p_in        = p_ff;
      psize_in    = psize_ff;
      res_in      = res_ff;
      moving_in   = moving_ff;
      sp_pos_in   = sp_pos_ff;
      sp_data_in  = sp_data_ff;
      run_in      = run_ff;
      grew_in     = grew_ff;
      run_pos_in  = run_pos_ff;
      run_size_in = run_size_ff;
      ftot_in     = ftot_ff;
      utot_in     = utot_ff;
      big_in      = big_ff;

      wr          = '0;
      fin         = 1'b0;
      fin_fail    = 1'b0;
      fin_status  = ffha_pkg::ST_DONE;
      fin_res     = '0;
      fin_src     = '0;
      fin_cnt     = '0;
      fin_ftot    = '0;
      fin_utot    = '0;
      fin_big     = '0;
      fail_len    = len_ff;

      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = ffha_pkg::op_type'(req_operation);
               len_in    = req_length;
               ptr_in    = req_pointer_offset;
               need_in   = (NEED_W'(req_length) + ffha_pkg::ALIGN_MASK) & ~ffha_pkg::ALIGN_MASK;
               pos_in    = '0;
               moving_in = 1'b0;
               fail_len  = req_length;
               unique case (ffha_pkg::op_type'(req_operation))
                  ffha_pkg::OP_FREE: begin
                     if (!req_pointer_given) begin
                        fin = 1'b1;
                     end else if (!ready) begin
                        fin        = 1'b1;
                        fin_status = ffha_pkg::ST_IGNORED;
                     end else begin
                        state_in = ffha_pkg::S_F_WALK;
                     end
                  end
                  ffha_pkg::OP_STATS: begin
                     if (!ready) begin
                        fin        = 1'b1;
                        fin_status = ffha_pkg::ST_NOT_READY;
                     end else begin
                        ftot_in  = '0;
                        utot_in  = '0;
                        big_in   = '0;
                        state_in = ffha_pkg::S_S_WALK;
                     end
                  end
                  default: begin
                     if (ffha_pkg::op_type'(req_operation) == ffha_pkg::OP_REALLOC &&
                         req_pointer_given) begin
                        if (!ready) begin
                           fin        = 1'b1;
                           fin_status = ffha_pkg::ST_IGNORED;
                        end else begin
                           state_in = ffha_pkg::S_F_WALK;
                        end
                     end else if (req_length == '0 || !ready) begin
                        fin        = 1'b1;
                        fin_fail   = 1'b1;
                        fin_status = ffha_pkg::ST_FAIL;
                     end else begin
                        state_in = ffha_pkg::S_A_WALK;
                     end
                  end
               endcase
            end
         end

         ffha_pkg::S_INIT: begin
            wr.en        = ready;
            wr.addr      = '0;
            wr.data.free = 1'b1;
            wr.data.size = cap - ffha_pkg::HDR_P;
            state_in     = ffha_pkg::S_IDLE;
         end

         ffha_pkg::S_A_WALK: begin
            if (at_end) begin
               fin        = 1'b1;
               fin_fail   = 1'b1;
               fin_status = ffha_pkg::ST_FAIL;
               state_in   = ffha_pkg::S_IDLE;
            end else if (hdr.free && NEED_W'(hdr.size) >= need_ff) begin
               wr.en        = 1'b1;
               wr.addr      = pos_ff[ffha_pkg::ALIGN_SH +: ffha_pkg::HDR_AW];
               wr.data.free = 1'b0;
               wr.data.size = blk_split ? SIZE_W'(need_ff) : hdr.size;
               sp_pos_in    = blk_rest_pos;
               sp_data_in   = '{free: 1'b1, size: blk_rest};
               res_in       = ffha_pkg::PTR_W'(pos_ff + ffha_pkg::HDR_P);
               if (blk_split) begin
                  state_in = ffha_pkg::S_SPLIT;
               end else if (moving_ff) begin
                  state_in = ffha_pkg::S_FREE_WR;
               end else begin
                  fin        = 1'b1;
                  fin_status = ffha_pkg::ST_PTR;
                  fin_res    = ffha_pkg::PTR_W'(pos_ff + ffha_pkg::HDR_P);
                  state_in   = ffha_pkg::S_IDLE;
               end
            end else begin
               pos_in = pos_next;
            end
         end

         ffha_pkg::S_SPLIT: begin
            wr.en   = 1'b1;
            wr.addr = sp_pos_ff[ffha_pkg::ALIGN_SH +: ffha_pkg::HDR_AW];
            wr.data = sp_data_ff;
            if (moving_ff) begin
               state_in = ffha_pkg::S_FREE_WR;
            end else begin
               fin        = 1'b1;
               fin_status = ffha_pkg::ST_PTR;
               fin_res    = res_ff;
               state_in   = ffha_pkg::S_IDLE;
            end
         end

         ffha_pkg::S_F_WALK: begin
            if (at_end || pos_ff + ffha_pkg::HDR_P > ptr_pos) begin
               fin        = 1'b1;
               fin_status = ffha_pkg::ST_IGNORED;
               state_in   = ffha_pkg::S_IDLE;
            end else if (pos_ff + ffha_pkg::HDR_P == ptr_pos) begin
               p_in     = pos_ff;
               psize_in = hdr.size;
               if (hdr.free) begin
                  fin        = 1'b1;
                  fin_status = ffha_pkg::ST_IGNORED;
                  state_in   = ffha_pkg::S_IDLE;
               end else if (op_ff == ffha_pkg::OP_FREE || len_ff == '0) begin
                  state_in = ffha_pkg::S_FREE_WR;
               end else if (NEED_W'(hdr.size) >= need_ff) begin
                  // shrink or keep in place
                  wr.en        = 1'b1;
                  wr.addr      = pos_ff[ffha_pkg::ALIGN_SH +: ffha_pkg::HDR_AW];
                  wr.data.free = 1'b0;
                  wr.data.size = blk_split ? SIZE_W'(need_ff) : hdr.size;
                  sp_pos_in    = blk_rest_pos;
                  sp_data_in   = '{free: 1'b1, size: blk_rest};
                  res_in       = ptr_ff;
                  if (blk_split) begin
                     state_in = ffha_pkg::S_SPLIT;
                  end else begin
                     fin        = 1'b1;
                     fin_status = ffha_pkg::ST_PTR;
                     fin_res    = ptr_ff;
                     state_in   = ffha_pkg::S_IDLE;
                  end
               end else if (pos_next >= cap) begin
                  moving_in = 1'b1;
                  pos_in    = '0;
                  state_in  = ffha_pkg::S_A_WALK;
               end else begin
                  pos_in   = pos_next;
                  state_in = ffha_pkg::S_R_NEXT;
               end
            end else begin
               pos_in = pos_next;
            end
         end

         ffha_pkg::S_R_NEXT: begin
            if (hdr.free && NEED_W'(comb_size) >= need_ff) begin
               // absorb the free neighbor, then split off what is left
               wr.en        = 1'b1;
               wr.addr      = p_ff[ffha_pkg::ALIGN_SH +: ffha_pkg::HDR_AW];
               wr.data.free = 1'b0;
               wr.data.size = blk_split ? SIZE_W'(need_ff) : comb_size;
               sp_pos_in    = blk_rest_pos;
               sp_data_in   = '{free: 1'b1, size: blk_rest};
               res_in       = ptr_ff;
               if (blk_split) begin
                  state_in = ffha_pkg::S_SPLIT;
               end else begin
                  fin        = 1'b1;
                  fin_status = ffha_pkg::ST_PTR;
                  fin_res    = ptr_ff;
                  state_in   = ffha_pkg::S_IDLE;
               end
            end else begin
               moving_in = 1'b1;
               pos_in    = '0;
               state_in  = ffha_pkg::S_A_WALK;
            end
         end

         ffha_pkg::S_FREE_WR: begin
            wr.en        = 1'b1;
            wr.addr      = p_ff[ffha_pkg::ALIGN_SH +: ffha_pkg::HDR_AW];
            wr.data.free = 1'b1;
            wr.data.size = psize_ff;
            state_in     = ffha_pkg::S_M_START;
         end

         ffha_pkg::S_M_START: begin
            pos_in   = '0;
            run_in   = 1'b0;
            grew_in  = 1'b0;
            state_in = ffha_pkg::S_M_WALK;
         end

         ffha_pkg::S_M_WALK: begin
            if (at_end || !hdr.free) begin
               // flush a grown run of free blocks into its first header
               wr.en        = run_ff && grew_ff;
               wr.addr      = run_pos_ff[ffha_pkg::ALIGN_SH +: ffha_pkg::HDR_AW];
               wr.data.free = 1'b1;
               wr.data.size = run_size_ff;
               run_in       = 1'b0;
               grew_in      = 1'b0;
            end else if (run_ff) begin
               run_size_in = run_size_ff + ffha_pkg::HDR_P + hdr.size;
               grew_in     = 1'b1;
            end else begin
               run_in      = 1'b1;
               grew_in     = 1'b0;
               run_pos_in  = pos_ff;
               run_size_in = hdr.size;
            end
            if (at_end) begin
               fin      = 1'b1;
               state_in = ffha_pkg::S_IDLE;
               if (moving_ff) begin
                  fin_status = ffha_pkg::ST_MOVED;
                  fin_res    = res_ff;
                  fin_src    = ptr_ff;
                  fin_cnt    = psize_ff;
               end
            end else begin
               pos_in = pos_next;
            end
         end

         ffha_pkg::S_S_WALK: begin
            if (at_end) begin
               fin      = 1'b1;
               fin_ftot = ftot_ff;
               fin_utot = utot_ff;
               fin_big  = big_ff;
               state_in = ffha_pkg::S_IDLE;
            end else begin
               if (hdr.free) begin
                  ftot_in = ftot_ff + hdr.size;
                  if (hdr.size > big_ff) begin
                     big_in = hdr.size;
                  end
               end else begin
                  utot_in = utot_ff + hdr.size;
               end
               pos_in = pos_next;
            end
         end

         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase

      fail_cnt_in  = fail_cnt_ff;
      last_fail_in = last_fail_ff;
      if (fin_fail) begin
         if (fail_cnt_ff != '1) begin
            fail_cnt_in = fail_cnt_ff + 1'b1;
         end
         last_fail_in = fail_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ffha_pkg::S_INIT;
         heap_bytes_ff <= ffha_pkg::HEAP_CAP;
         fail_cnt_ff   <= '0;
         last_fail_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         moving_ff     <= 1'b0;
         run_ff        <= 1'b0;
         grew_ff       <= 1'b0;
      end else if (csr_wr) begin
         state_ff      <= ffha_pkg::S_INIT;
         heap_bytes_ff <= csr_pwdata[ffha_pkg::CFG_W-1:0];
         fail_cnt_ff   <= '0;
         last_fail_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
         moving_ff     <= 1'b0;
         run_ff        <= 1'b0;
         grew_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fail_cnt_ff  <= fail_cnt_in;
         last_fail_ff <= last_fail_in;
         rsp_valid_ff <= fin;
         moving_ff    <= moving_in;
         run_ff       <= run_in;
         grew_ff      <= grew_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      len_ff      <= len_in;
      ptr_ff      <= ptr_in;
      need_ff     <= need_in;
      pos_ff      <= pos_in;
      p_ff        <= p_in;
      psize_ff    <= psize_in;
      res_ff      <= res_in;
      sp_pos_ff   <= sp_pos_in;
      sp_data_ff  <= sp_data_in;
      run_pos_ff  <= run_pos_in;
      run_size_ff <= run_size_in;
      ftot_ff     <= ftot_in;
      utot_ff     <= utot_in;
      big_ff      <= big_in;
      if (fin) begin
         rsp_status_ff <= fin_status;
         rsp_res_ff    <= fin_res;
         rsp_src_ff    <= fin_src;
         rsp_cnt_ff    <= fin_cnt;
         rsp_ftot_ff   <= fin_ftot;
         rsp_utot_ff   <= fin_utot;
         rsp_big_ff    <= fin_big;
         rsp_fails_ff  <= fail_cnt_in;
         rsp_lastf_ff  <= last_fail_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_result_offset    = rsp_res_ff;
   assign rsp_copy_source      = rsp_src_ff;
   assign rsp_copy_bytes       = rsp_cnt_ff;
   assign rsp_free_total       = rsp_ftot_ff;
   assign rsp_used_total       = rsp_utot_ff;
   assign rsp_largest_free     = rsp_big_ff;
   assign rsp_failures_seen    = rsp_fails_ff;
   assign rsp_last_failed_size = rsp_lastf_ff;

endmodule

// ===== src/ffha_hdr_ram.sv =====
// Block header store: one entry per alignment unit, one write and one read port.
// Read data is registered. Depends on ffha_pkg.
module ffha_hdr_ram (
   input  logic                            clock,
   input  ffha_pkg::ram_wr_type            wr,
   input  logic [ffha_pkg::HDR_AW-1:0]     rd_addr,
   output ffha_pkg::hdr_type               rd_data_ff
);

   ffha_pkg::hdr_type mem [ffha_pkg::HDR_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// ===== sim/tb_first_fit_heap_allocator.sv =====
// Self-checking testbench for first_fit_heap_allocator: a block-list predictor in a
// scoreboard class, plain tasks for the request and APB ports. Depends on ffha_pkg.
module tb_first_fit_heap_allocator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam int MAX_BLK = ffha_pkg::HEAP_BYTES /
                            (ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES) + 1;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [1:0]                    req_operation = '0;
   logic                          req_pointer_given = 1'b0;
   logic [ffha_pkg::PTR_W-1:0]    req_pointer_offset = '0;
   logic [ffha_pkg::LEN_W-1:0]    req_length = '0;
   logic                          rsp_valid;
   logic [2:0]                    rsp_status;
   logic [ffha_pkg::PTR_W-1:0]    rsp_result_offset;
   logic [ffha_pkg::PTR_W-1:0]    rsp_copy_source;
   logic [ffha_pkg::SIZE_W-1:0]   rsp_copy_bytes;
   logic [ffha_pkg::SIZE_W-1:0]   rsp_free_total;
   logic [ffha_pkg::SIZE_W-1:0]   rsp_used_total;
   logic [ffha_pkg::SIZE_W-1:0]   rsp_largest_free;
   logic [ffha_pkg::CNT_W-1:0]    rsp_failures_seen;
   logic [ffha_pkg::LEN_W-1:0]    rsp_last_failed_size;
   logic                          csr_psel = 1'b0;
   logic                          csr_penable = 1'b0;
   logic                          csr_pwrite = 1'b0;
   logic [1:0]                    csr_paddr = '0;
   logic [31:0]                   csr_pwdata = '0;
   logic [31:0]                   csr_prdata;
   logic                          csr_pready;

   int errors = 0;
   int idle_cycles = 0;

   first_fit_heap_allocator dut (.*);

   always #2 clock = ~clock;

   typedef struct {
      logic [2:0]                  status;
      logic [ffha_pkg::PTR_W-1:0]  offset;
      logic [ffha_pkg::PTR_W-1:0]  src;
      logic [ffha_pkg::SIZE_W-1:0] bytes;
      logic [ffha_pkg::SIZE_W-1:0] ftot;
      logic [ffha_pkg::SIZE_W-1:0] utot;
      logic [ffha_pkg::SIZE_W-1:0] big;
      logic [ffha_pkg::CNT_W-1:0]  fails;
      logic [ffha_pkg::LEN_W-1:0]  last_fail;
   } heap_rsp_type;

   task automatic report(string field, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   class heap_scoreboard;
      int unsigned  sizes[$];
      bit           frees[$];
      int unsigned  fail_count;
      int unsigned  last_fail;
      heap_rsp_type pending[$];

      function void configure(int unsigned bytes);
         int unsigned cap;
         cap = bytes > ffha_pkg::HEAP_BYTES ? ffha_pkg::HEAP_BYTES : bytes;
         cap -= cap % ffha_pkg::ALIGN_BYTES;
         sizes.delete();
         frees.delete();
         if (cap >= ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES) begin
            sizes.push_back(cap - ffha_pkg::HEADER_BYTES);
            frees.push_back(1'b1);
         end
         fail_count = 0;
         last_fail = 0;
      endfunction

      function int unsigned payload(int idx);
         int unsigned pos;
         pos = 0;
         for (int i = 0; i < idx; i++) pos += ffha_pkg::HEADER_BYTES + sizes[i];
         return pos + ffha_pkg::HEADER_BYTES;
      endfunction

      function int locate(int unsigned ptr);
         for (int i = 0; i < sizes.size(); i++)
            if (payload(i) == ptr) return i;
         return -1;
      endfunction

      // offset of a random block with the given flag, or a random offset if none
      function int unsigned pick(bit want_free);
         int hits[$];
         for (int i = 0; i < sizes.size(); i++)
            if (frees[i] == want_free) hits.push_back(i);
         if (hits.size() == 0) return $urandom_range(65535);
         return payload(hits[$urandom_range(hits.size() - 1)]);
      endfunction

      function void split(int idx, int unsigned need);
         if (sizes.size() >= MAX_BLK) return;
         if (sizes[idx] < need + ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES) return;
         sizes.insert(idx + 1, sizes[idx] - need - ffha_pkg::HEADER_BYTES);
         frees.insert(idx + 1, 1'b1);
         sizes[idx] = need;
      endfunction

      function void count_fail(int unsigned len);
         if (fail_count != 32'hFFFF_FFFF) fail_count++;
         last_fail = len & 24'hFF_FFFF;
      endfunction

      function int unsigned round8(int unsigned len);
         return (len + ffha_pkg::ALIGN_BYTES - 1) / ffha_pkg::ALIGN_BYTES *
                ffha_pkg::ALIGN_BYTES;
      endfunction

      function int alloc(int unsigned len);
         int unsigned need;
         if (len == 0) begin
            count_fail(len);
            return -1;
         end
         need = round8(len);
         for (int i = 0; i < sizes.size(); i++)
            if (frees[i] && sizes[i] >= need) begin
               split(i, need);
               frees[i] = 1'b0;
               return payload(i);
            end
         count_fail(len);
         return -1;
      endfunction

      function ffha_pkg::status_type release_ptr(int unsigned ptr);
         int idx, i;
         idx = locate(ptr);
         if (idx < 0 || frees[idx]) return ffha_pkg::ST_IGNORED;
         frees[idx] = 1'b1;
         i = 0;
         while (i + 1 < sizes.size()) begin
            if (frees[i] && frees[i+1]) begin
               sizes[i] += ffha_pkg::HEADER_BYTES + sizes[i+1];
               sizes.delete(i + 1);
               frees.delete(i + 1);
            end else begin
               i++;
            end
         end
         return ffha_pkg::ST_DONE;
      endfunction

      function void note_request(ffha_pkg::op_type op, bit given, int unsigned ptr,
                                 int unsigned len);
         heap_rsp_type e;
         int r, idx;
         int unsigned need, old;
         e = '{status: ffha_pkg::ST_DONE, default: '0};
         if (op == ffha_pkg::OP_ALLOC || (op == ffha_pkg::OP_REALLOC && !given)) begin
            r = alloc(len);
            if (r < 0) e.status = ffha_pkg::ST_FAIL;
            else begin
               e.status = ffha_pkg::ST_PTR;
               e.offset = r;
            end
         end else if (op == ffha_pkg::OP_FREE) begin
            e.status = given ? release_ptr(ptr) : ffha_pkg::ST_DONE;
         end else if (op == ffha_pkg::OP_REALLOC) begin
            if (len == 0) e.status = release_ptr(ptr);
            else begin
               need = round8(len);
               idx = locate(ptr);
               if (idx < 0 || frees[idx]) e.status = ffha_pkg::ST_IGNORED;
               else if (sizes[idx] >= need) begin
                  split(idx, need);
                  e.status = ffha_pkg::ST_PTR;
                  e.offset = ptr;
               end else if (idx + 1 < sizes.size() && frees[idx+1] &&
                            sizes[idx] + ffha_pkg::HEADER_BYTES + sizes[idx+1] >= need) begin
                  sizes[idx] += ffha_pkg::HEADER_BYTES + sizes[idx+1];
                  sizes.delete(idx + 1);
                  frees.delete(idx + 1);
                  split(idx, need);
                  e.status = ffha_pkg::ST_PTR;
                  e.offset = ptr;
               end else begin
                  old = sizes[idx];
                  r = alloc(len);
                  if (r < 0) e.status = ffha_pkg::ST_FAIL;
                  else begin
                     void'(release_ptr(ptr));
                     e.status = ffha_pkg::ST_MOVED;
                     e.offset = r;
                     e.src = ptr;
                     e.bytes = old;
                  end
               end
            end
         end else begin
            if (sizes.size() == 0) e.status = ffha_pkg::ST_NOT_READY;
            else begin
               for (int i = 0; i < sizes.size(); i++)
                  if (frees[i]) begin
                     e.ftot += sizes[i];
                     if (sizes[i] > e.big) e.big = sizes[i];
                  end else begin
                     e.utot += sizes[i];
                  end
            end
         end
         e.fails = fail_count;
         e.last_fail = last_fail;
         pending.push_back(e);
      endfunction

      task check_result(heap_rsp_type got);
         heap_rsp_type w;
         if (pending.size() == 0) begin
            report("unexpected result", got.status, 0);
            return;
         end
         w = pending.pop_front();
         if (got.status !== w.status) report("status", got.status, w.status);
         if (got.offset !== w.offset) report("result_offset", got.offset, w.offset);
         if (got.src !== w.src) report("copy_source", got.src, w.src);
         if (got.bytes !== w.bytes) report("copy_bytes", got.bytes, w.bytes);
         if (got.ftot !== w.ftot) report("free_total", got.ftot, w.ftot);
         if (got.utot !== w.utot) report("used_total", got.utot, w.utot);
         if (got.big !== w.big) report("largest_free", got.big, w.big);
         if (got.fails !== w.fails) report("failures_seen", got.fails, w.fails);
         if (got.last_fail !== w.last_fail)
            report("last_failed_size", got.last_fail, w.last_fail);
      endtask
   endclass

   heap_scoreboard sb = new();

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result('{rsp_status, rsp_result_offset, rsp_copy_source, rsp_copy_bytes,
                           rsp_free_total, rsp_used_total, rsp_largest_free,
                           rsp_failures_seen, rsp_last_failed_size});
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_item(ffha_pkg::op_type op, bit given, int unsigned ptr,
                            int unsigned len);
      int gap;
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_pointer_given <= given;
      req_pointer_offset <= ptr[ffha_pkg::PTR_W-1:0];
      req_length <= len[ffha_pkg::LEN_W-1:0];
      do @(posedge clock); while (busy);
      sb.note_request(op, given, ptr[ffha_pkg::PTR_W-1:0], len & 24'hFF_FFFF);
   endtask

   // let the heap go quiet, then rewrite heap_bytes
   task automatic set_heap_bytes(int unsigned bytes);
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0 || busy) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= bytes;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.configure(bytes & 32'h1FFFF);
      @(posedge clock);
      @(posedge clock);
   endtask

   task automatic random_item();
      int unsigned sel, len, ptr;
      bit given;
      sel = $urandom_range(99);
      case ($urandom_range(9))
         0: len = 0;
         1: len = $urandom;
         2: len = $urandom_range(4096);
         default: len = $urandom_range(1, 160);
      endcase
      given = ($urandom_range(9) != 0);
      case ($urandom_range(9))
         0: ptr = $urandom_range(65535);
         1: ptr = sb.pick(1'b1);
         default: ptr = sb.pick(1'b0);
      endcase
      if (sel < 35) send_item(ffha_pkg::OP_ALLOC, $urandom_range(1), $urandom_range(65535), len);
      else if (sel < 65) send_item(ffha_pkg::OP_FREE, given, ptr, len);
      else if (sel < 90) send_item(ffha_pkg::OP_REALLOC, given, ptr, len);
      else send_item(ffha_pkg::OP_STATS, $urandom_range(1), ptr, len);
   endtask

   initial begin
      int unsigned heap_sizes[8] = '{65536, 0, 23, 24, 300, 2000, 131071, 1000};
      int unsigned a, b, c;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      sb.configure(65536);
      @(posedge clock);

      // directed: zero, huge, null and bogus pointers, shrink, grow, move, double free
      send_item(ffha_pkg::OP_STATS, 0, 0, 0);
      send_item(ffha_pkg::OP_ALLOC, 0, 0, 0);
      send_item(ffha_pkg::OP_ALLOC, 0, 0, 24'hFF_FFFF);
      send_item(ffha_pkg::OP_ALLOC, 0, 0, 1);
      a = sb.pick(1'b0);
      send_item(ffha_pkg::OP_ALLOC, 0, 0, 100);
      send_item(ffha_pkg::OP_ALLOC, 0, 0, 40);
      send_item(ffha_pkg::OP_FREE, 0, 0, 0);
      send_item(ffha_pkg::OP_FREE, 1, 16'hFFFF, 0);
      send_item(ffha_pkg::OP_FREE, 1, 24, 0);
      b = sb.payload(1);
      send_item(ffha_pkg::OP_REALLOC, 1, b, 16);
      send_item(ffha_pkg::OP_REALLOC, 1, b, 64);
      send_item(ffha_pkg::OP_REALLOC, 1, a, 500);
      send_item(ffha_pkg::OP_REALLOC, 0, 0, 33);
      c = sb.pick(1'b0);
      send_item(ffha_pkg::OP_REALLOC, 1, c, 0);
      send_item(ffha_pkg::OP_REALLOC, 1, c, 0);
      send_item(ffha_pkg::OP_REALLOC, 1, c, 8);
      send_item(ffha_pkg::OP_FREE, 1, sb.pick(1'b0), 0);
      send_item(ffha_pkg::OP_REALLOC, 1, sb.pick(1'b0), 65000);
      send_item(ffha_pkg::OP_ALLOC, 0, 0, 65536 - 16 * 8);
      send_item(ffha_pkg::OP_STATS, 1, 16'hFFFF, 24'hFF_FFFF);

      for (int p = 0; p < 8; p++) begin
         set_heap_bytes(heap_sizes[p]);
         if (heap_sizes[p] < 100) begin
            send_item(ffha_pkg::OP_FREE, 1, 16, 0);
            send_item(ffha_pkg::OP_REALLOC, 1, 16, 8);
            send_item(ffha_pkg::OP_STATS, 0, 0, 0);
            send_item(ffha_pkg::OP_ALLOC, 0, 0, 8);
         end
         repeat (p == 0 || p == 6 ? 580 : 110) random_item();
      end

      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && sb.pending.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
